### hdl/plc_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none

package plc_pkg;

  localparam int PLC_CAPACITY   = 64;
  localparam int PLC_DATA_WIDTH = 32;

  // Fixed port field widths
  localparam int PLC_KIND_W  = 3;
  localparam int PLC_POS_W   = 7;
  localparam int PLC_OTHER_W = 6;
  localparam int PLC_VALUE_W = 32;
  localparam int PLC_WIDE_W  = 64;

  typedef enum logic [PLC_KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_READ   = 3'd3,
    KIND_SWAP   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SWAP
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMMIT
  } state_t;

endpackage

`default_nettype wire

### hdl/plc_cell.sv
// One list slot: holds an entry, shifts it with its neighbors, or swaps it using the read-out words.
`default_nettype none

module plc_cell import plc_pkg::*; #(
  parameter int DATA_WIDTH = PLC_DATA_WIDTH,
  parameter int CMP_W      = PLC_POS_W,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_op_t              cmd,
  input  logic [CMP_W-1:0]      tgt,
  input  logic [CMP_W-1:0]      tgt2,
  input  logic [CMP_W-1:0]      cnt,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] val_a,
  input  logic [DATA_WIDTH-1:0] val_b,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] part_a,
  output logic [DATA_WIDTH-1:0] part_b
);

  localparam logic [CMP_W-1:0] IDX      = CMP_W'(INDEX);
  localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd)
      CELL_INSERT: begin
        if (IDX == tgt) begin
          data_next = word;
        end else if (IDX > tgt && IDX <= cnt) begin
          data_next = left_data;
        end
      end
      CELL_REMOVE: begin
        if (IDX >= tgt && IDX_NEXT < cnt) begin
          data_next = right_data;
        end
      end
      CELL_SWAP: begin
        if (IDX == tgt) begin
          data_next = val_b;
        end else if (IDX == tgt2) begin
          data_next = val_a;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Masked contributions to the read-out OR trees
  assign part_a = (IDX == tgt)  ? data : '0;
  assign part_b = (IDX == tgt2) ? data : '0;

endmodule

`default_nettype wire

### hdl/positional_list_engine_core.sv
// Ordered list of up to CAPACITY words held in a row of cells that shift in parallel.
// A request is taken only when the engine is idle. A read stage then picks the addressed
// words out of the cell row through an OR tree and checks ranges, and a commit stage has
// every cell shift or swap in parallel and writes the result; the next request is accepted
// only once the engine is back in idle, so requests do not overlap. The result sits in an
// output register, so a new request is taken while the previous result still waits; a
// commit stalls only if that register is still full.
// Entries need no clearing after reset: only positions below the count are ever read.
`default_nettype none

module positional_list_engine_core import plc_pkg::*; #(
  parameter int CAPACITY   = PLC_CAPACITY,
  parameter int DATA_WIDTH = PLC_DATA_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [PLC_KIND_W-1:0]  kind,
  input  logic [PLC_POS_W-1:0]   position,
  input  logic [PLC_OTHER_W-1:0] other_position,
  input  logic [PLC_VALUE_W-1:0] item_value,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic                   ok,
  output logic [PLC_VALUE_W-1:0] out_value,
  output logic [PLC_POS_W-1:0]   element_count,
  output logic                   is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > PLC_POS_W) ? CNT_W : PLC_POS_W;

  state_t state, state_next;

  kind_t                 req_kind;
  logic [CMP_W-1:0]      tgt;
  logic [CMP_W-1:0]      tgt2;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic                  op_ok;
  cell_op_t              cell_op;
  logic [CNT_W-1:0]      cnt;

  logic                  req_fire;
  logic                  commit_go;
  logic                  op_ok_next;
  cell_op_t              cell_op_next;
  cell_op_t              cell_cmd;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CNT_W-1:0]      cnt_next;
  logic [PLC_WIDE_W-1:0] word_wide;
  logic [PLC_WIDE_W-1:0] out_wide;
  logic [CMP_W-1:0]      cnt_after;
  logic [DATA_WIDTH-1:0] or_a;
  logic [DATA_WIDTH-1:0] or_b;

  logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_left  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_right [CAPACITY];
  logic [DATA_WIDTH-1:0] part_a     [CAPACITY];
  logic [DATA_WIDTH-1:0] part_b     [CAPACITY];

  assign cnt_ext   = CMP_W'(cnt);
  assign word_wide = PLC_WIDE_W'(item_value);
  assign out_wide  = PLC_WIDE_W'(rd_a);
  assign cell_cmd  = commit_go ? cell_op : CELL_HOLD;

  // FSM: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_COMMIT;
      ST_COMMIT: if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    req_ready = 1'b0;
    commit_go = 1'b0;
    case (state)
      ST_IDLE:   req_ready = 1'b1;
      ST_COMMIT: commit_go = !rsp_valid || rsp_ready;
      default: begin
        req_ready = 1'b0;
        commit_go = 1'b0;
      end
    endcase
  end

  assign req_fire = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Range checks, evaluated in the read stage
  always_comb begin
    op_ok_next   = 1'b0;
    cell_op_next = CELL_HOLD;
    case (req_kind)
      KIND_APPEND, KIND_INSERT: begin
        if (cnt_ext < CMP_W'(CAPACITY) && tgt <= cnt_ext) begin
          op_ok_next   = 1'b1;
          cell_op_next = CELL_INSERT;
        end
      end
      KIND_REMOVE: begin
        if (tgt < cnt_ext) begin
          op_ok_next   = 1'b1;
          cell_op_next = CELL_REMOVE;
        end
      end
      KIND_READ: begin
        op_ok_next = tgt < cnt_ext;
      end
      KIND_SWAP: begin
        if (tgt < cnt_ext && tgt2 < cnt_ext) begin
          op_ok_next   = 1'b1;
          cell_op_next = CELL_SWAP;
        end
      end
      default: begin
        op_ok_next   = 1'b0;
        cell_op_next = CELL_HOLD;
      end
    endcase
  end

  // OR trees gathering the addressed words
  always_comb begin
    or_a = '0;
    or_b = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      or_a = or_a | part_a[i];
      or_b = or_b | part_b[i];
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (op_ok && cell_op == CELL_INSERT) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (op_ok && cell_op == CELL_REMOVE) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  assign cnt_after = CMP_W'(cnt_next);

  // Request capture and read stage
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_kind <= kind_t'(kind);
      tgt      <= (kind_t'(kind) == KIND_APPEND) ? cnt_ext : CMP_W'(position);
      tgt2     <= CMP_W'(other_position);
      word     <= word_wide[DATA_WIDTH-1:0];
    end
    if (state == ST_READ) begin
      rd_a <= or_a;
      rd_b <= or_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_ok   <= 1'b0;
      cell_op <= CELL_HOLD;
      cnt     <= '0;
    end else begin
      if (state == ST_READ) begin
        op_ok   <= op_ok_next;
        cell_op <= cell_op_next;
      end
      if (commit_go) begin
        cnt <= cnt_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      ok            <= op_ok;
      out_value     <= (op_ok && (req_kind == KIND_REMOVE || req_kind == KIND_READ))
                       ? out_wide[PLC_VALUE_W-1:0] : '0;
      element_count <= cnt_after[PLC_POS_W-1:0];
      is_empty      <= (cnt_next == '0);
    end
  end

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_left[g] = '0;
    end else begin : g_inner_l
      assign cell_left[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign cell_right[g] = '0;
    end else begin : g_inner_r
      assign cell_right[g] = cell_data[g+1];
    end

    plc_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CMP_W      (CMP_W),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .tgt        (tgt),
      .tgt2       (tgt2),
      .cnt        (cnt_ext),
      .word       (word),
      .val_a      (rd_a),
      .val_b      (rd_b),
      .left_data  (cell_left[g]),
      .right_data (cell_right[g]),
      .data       (cell_data[g]),
      .part_a     (part_a[g]),
      .part_b     (part_b[g])
    );
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cnt) <= CAPACITY)
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (int'(cnt) - int'($past(cnt)) <= 1) && (int'($past(cnt)) - int'(cnt) <= 1))
    else $error("entry count moved by more than one");

  a_cnt_commit: assert property (@(posedge clk) disable iff (rst)
    (cnt != $past(cnt)) |-> $past(state == ST_COMMIT))
    else $error("entry count changed outside commit");

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_COMMIT))
    else $error("result raised without a commit");

endmodule

`default_nettype wire

### tb/positional_list_engine_core_test.sv
// Self-checking testbench for the positional list engine: directed, then random requests against a list predictor.
module positional_list_engine_core_test;
  import plc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TOTAL = 1250;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    kind_t                  op;
    logic [PLC_POS_W-1:0]   pos;
    logic [PLC_OTHER_W-1:0] other;
    logic [PLC_VALUE_W-1:0] value;
  } list_req_t;

  typedef struct {
    logic                   ok;
    logic [PLC_VALUE_W-1:0] value;
    logic [PLC_POS_W-1:0]   count;
    logic                   empty;
  } list_rsp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  logic [PLC_KIND_W-1:0]  kind = '0;
  logic [PLC_POS_W-1:0]   position = '0;
  logic [PLC_OTHER_W-1:0] other_position = '0;
  logic [PLC_VALUE_W-1:0] item_value = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  logic                   ok;
  logic [PLC_VALUE_W-1:0] out_value;
  logic [PLC_POS_W-1:0]   element_count;
  logic                   is_empty;

  list_req_t pending_requests[$];
  list_rsp_t predicted_results[$];

  // predictor state: packed list in order
  logic [PLC_DATA_WIDTH-1:0] list_words [PLC_CAPACITY];
  int list_len = 0;

  int planned_len = 0;
  int fail_count = 0;
  int results_seen = 0;
  logic quiet_tail = 1'b0;

  positional_list_engine_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .kind(kind), .position(position), .other_position(other_position),
    .item_value(item_value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .ok(ok), .out_value(out_value), .element_count(element_count), .is_empty(is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // queue one request and track the list length it leads to
  task automatic plan_request(kind_t op, int pos, int other, logic [PLC_VALUE_W-1:0] value);
    list_req_t r;
    r.op = op;
    r.pos = pos[PLC_POS_W-1:0];
    r.other = other[PLC_OTHER_W-1:0];
    r.value = value;
    pending_requests.push_back(r);
    case (op)
      KIND_APPEND: if (planned_len < PLC_CAPACITY) planned_len++;
      KIND_INSERT: if (planned_len < PLC_CAPACITY && pos <= planned_len) planned_len++;
      KIND_REMOVE: if (pos < planned_len) planned_len--;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int phase;
    int phase_left;
    int roll;
    int pos;
    int other;
    kind_t op;
    logic [PLC_VALUE_W-1:0] value;
    int grow_thr [3][4];

    // operations on an empty list all fail
    plan_request(KIND_READ, 0, 0, '0);
    plan_request(KIND_REMOVE, 0, 0, '0);
    plan_request(KIND_SWAP, 0, 0, '0);
    plan_request(KIND_INSERT, 1, 0, '1);
    // build five entries; insert at the count acts as an append
    plan_request(KIND_INSERT, 0, 0, 32'hFFFF_FFFF);
    plan_request(KIND_APPEND, 0, 0, 32'h0000_0000);
    plan_request(KIND_INSERT, 2, 0, 32'h8000_0001);
    plan_request(KIND_INSERT, 1, 63, 32'h1234_5678);
    plan_request(KIND_APPEND, 64, 63, 32'hA5A5_5A5A);
    plan_request(KIND_READ, 0, 0, '0);
    plan_request(KIND_READ, 4, 0, '0);
    plan_request(KIND_READ, 5, 0, '0);
    plan_request(KIND_READ, 64, 0, '0);
    plan_request(KIND_SWAP, 1, 1, '0);
    plan_request(KIND_SWAP, 0, 4, '0);
    plan_request(KIND_SWAP, 0, 5, '0);
    plan_request(KIND_SWAP, 5, 0, '0);
    plan_request(KIND_SWAP, 64, 0, '0);
    plan_request(KIND_INSERT, 6, 0, 32'h5555_AAAA);
    plan_request(KIND_INSERT, 64, 0, 32'h5555_AAAA);
    plan_request(KIND_REMOVE, 4, 0, '0);
    plan_request(KIND_REMOVE, 0, 0, '0);
    plan_request(KIND_REMOVE, 64, 0, '0);
    plan_request(KIND_READ, 2, 0, '0);
    plan_request(KIND_SWAP, 2, 0, '0);

    // cumulative percent thresholds: append, insert, remove, read; rest is swap
    grow_thr[0] = '{40, 75, 85, 93};
    grow_thr[1] = '{10, 20, 70, 85};
    grow_thr[2] = '{20, 40, 60, 80};
    phase = 0;
    phase_left = 0;
    while (pending_requests.size() < ITEM_TOTAL) begin
      if (phase_left == 0) begin
        phase = $urandom_range(0, 2);
        phase_left = $urandom_range(60, 200);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < grow_thr[phase][0]) op = KIND_APPEND;
      else if (roll < grow_thr[phase][1]) op = KIND_INSERT;
      else if (roll < grow_thr[phase][2]) op = KIND_REMOVE;
      else if (roll < grow_thr[phase][3]) op = KIND_READ;
      else op = KIND_SWAP;
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 64);
      else if (op == KIND_INSERT) pos = $urandom_range(0, planned_len);
      else pos = (planned_len == 0) ? 0 : $urandom_range(0, planned_len - 1);
      if ($urandom_range(0, 9) == 0 || planned_len == 0) other = $urandom_range(0, 63);
      else other = $urandom_range(0, planned_len - 1);
      roll = $urandom_range(0, 19);
      if (roll == 0) value = '0;
      else if (roll == 1) value = '1;
      else value = $urandom;
      plan_request(op, pos, other, value);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_requests.size() != 0 || req_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // request side: new transaction only once the previous one is taken
  always @(posedge clk) begin : request_driver
    static int req_gap = 0;
    static int req_seg = 0;
    static int req_idle_pct = 0;
    list_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      quiet_tail <= (pending_requests.size() <= TAIL_ITEMS);
      if (!req_valid || req_ready) begin
        if (req_seg == 0) begin
          req_seg = $urandom_range(20, 120);
          req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        end else begin
          req_seg--;
        end
        if (req_gap == 0 && pending_requests.size() > TAIL_ITEMS &&
            $urandom_range(0, 99) < req_idle_pct)
          req_gap = $urandom_range(1, 11);
        if (req_gap > 0 || pending_requests.size() == 0) begin
          if (req_gap > 0) req_gap--;
          req_valid <= 1'b0;
        end else begin
          nxt = pending_requests.pop_front();
          req_valid <= 1'b1;
          kind <= nxt.op;
          position <= nxt.pos;
          other_position <= nxt.other;
          item_value <= nxt.value;
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off to back up the engine
  always @(posedge clk) begin : response_sink
    static int rsp_gap = 0;
    static int rsp_seg = 0;
    static int rsp_idle_pct = 0;
    static bit hold_done = 1'b0;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_seg == 0) begin
        rsp_seg = $urandom_range(20, 120);
        rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end else begin
        rsp_seg--;
      end
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rsp_gap = HOLD_CYCLES;
      end else if (rsp_gap == 0 && !quiet_tail && $urandom_range(0, 99) < rsp_idle_pct) begin
        rsp_gap = $urandom_range(1, 11);
      end
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // check results first, then predict for a request taken at this edge
  always @(posedge clk) begin : scoreboard
    list_rsp_t got;
    list_rsp_t want;
    logic [PLC_DATA_WIDTH-1:0] tmp;
    int p;
    int p2;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        results_seen <= results_seen + 1;
        got = '{ok, out_value, element_count, is_empty};
        if (predicted_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("out_value: expected %08h, got %08h", want.value, got.value);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("element_count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
          if (got.empty !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        want.ok = 1'b0;
        want.value = '0;
        p = position;
        p2 = other_position;
        case (kind_t'(kind))
          KIND_APPEND: begin
            if (list_len < PLC_CAPACITY) begin
              list_words[list_len] = item_value;
              list_len++;
              want.ok = 1'b1;
            end
          end
          KIND_INSERT: begin
            if (list_len < PLC_CAPACITY && p <= list_len) begin
              for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
              list_words[p] = item_value;
              list_len++;
              want.ok = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (p < list_len) begin
              want.value = list_words[p];
              for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
              list_len--;
              want.ok = 1'b1;
            end
          end
          KIND_READ: begin
            if (p < list_len) begin
              want.value = list_words[p];
              want.ok = 1'b1;
            end
          end
          KIND_SWAP: begin
            if (p < list_len && p2 < list_len) begin
              tmp = list_words[p];
              list_words[p] = list_words[p2];
              list_words[p2] = tmp;
              want.ok = 1'b1;
            end
          end
          default: ;
        endcase
        want.count = list_len[PLC_POS_W-1:0];
        want.empty = (list_len == 0);
        predicted_results.push_back(want);
      end
    end
  end

endmodule
